[rtl/ter_pkg.sv]
// Shared types and constants for the triangle edge rasterizer.
`default_nettype none

package ter_pkg;

    // Field widths
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 16;
    localparam int DX_W    = X_W + 1;
    localparam int DY_W    = Y_W + 1;

    // Stream widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // Default line pitch of the frame buffer
    localparam int SCREEN_W_DEF = 320;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic [X_W-1:0]     ter_x_t;
    typedef logic [Y_W-1:0]     ter_y_t;
    typedef logic [COLOR_W-1:0] ter_color_t;
    typedef logic [DX_W-1:0]    ter_dx_t;
    typedef logic [DY_W-1:0]    ter_dy_t;

    // One unpacked input request
    typedef struct packed {
        logic       op;
        ter_x_t     ax;
        ter_y_t     ay;
        ter_x_t     bx;
        ter_y_t     by_coord;
        ter_x_t     cx;
        ter_y_t     cy;
        ter_color_t paint;
    } ter_item_t;

    // One scanned position with the differences its edge functions need
    typedef struct packed {
        ter_x_t          x;
        ter_y_t          y;
        ter_color_t      color;
        logic            last;
        ter_dx_t [2:0]   dxp;
        ter_dy_t [2:0]   dyp;
        ter_dx_t [2:0]   ex;
        ter_dy_t [2:0]   ey;
    } ter_pix_t;

endpackage

`default_nettype wire

[rtl/triangle_edge_rasterizer.sv]
// A step request accepted on s_tdata shows its result on m_tdata after the registers listed below.
// Throughput: one request per cycle, steps and loads alike, while m_tready does not stall the output,
// set by the input register, the scan register, the edge-product register and the result register in line.
// A load gives no result; a step with no triangle loaded or a finished box gives none.
// Reset (aresetn low, synchronous) empties every stage and marks no triangle loaded.
// Top level: input register feeding the scan sequencer and the edge stages.
`default_nettype none

module triangle_edge_rasterizer import ter_pkg::*; #(
    parameter int SCREEN_W = SCREEN_W_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // ax, ay, bx, by_coord, cx, cy, paint, zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // operation
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_color, zero fill
    output logic [M_DATA_W-1:0]      m_tdata,
    // covered
    output logic                     m_tuser,
    output logic                     m_tlast
);

    logic                in_valid_reg, in_valid_next;
    logic                in_op_reg;
    logic [S_DATA_W-1:0] in_data_reg;
    ter_item_t           item;
    logic                in_take;
    logic                pix_valid;
    logic                pix_ready;
    ter_pix_t            pix;

    // Hold a request until the scan sequencer takes it
    assign s_tready      = !in_valid_reg || in_take;
    assign in_valid_next = (in_valid_reg && !in_take) || (s_tvalid && s_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Unpack the held request
    always_comb begin
        item.op       = in_op_reg;
        item.ax       = in_data_reg[8:0];
        item.ay       = in_data_reg[16:9];
        item.bx       = in_data_reg[25:17];
        item.by_coord = in_data_reg[33:26];
        item.cx       = in_data_reg[42:34];
        item.cy       = in_data_reg[50:43];
        item.paint    = in_data_reg[58:51];
    end

    ter_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .item      (item),
        .in_take   (in_take),
        .dn_ready  (pix_ready),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    ter_edge #(
        .SCREEN_W (SCREEN_W)
    ) u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_ready (pix_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/ter_scan.sv]
// Triangle store and bounding-box scan sequencer.
`default_nettype none

module ter_scan import ter_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire ter_item_t item,
    output logic           in_take,
    input  wire logic      dn_ready,
    output logic           pix_valid,
    output ter_pix_t       pix
);

    logic       active_reg, active_next;
    ter_x_t     vx_reg [3];
    ter_y_t     vy_reg [3];
    ter_dx_t    ex_reg [3];
    ter_dy_t    ey_reg [3];
    ter_color_t color_reg;
    ter_x_t     scan_x_reg, scan_x_next;
    ter_y_t     scan_y_reg, scan_y_next;
    ter_x_t     left_reg, left_next;
    ter_x_t     right_reg, right_next;
    ter_y_t     bottom_reg, bottom_next;
    logic       pix_valid_reg, pix_valid_next;
    ter_pix_t   pix_reg, pix_next;

    ter_x_t     in_x [3];
    ter_y_t     in_y [3];
    logic       is_load;
    logic       emit;
    logic       pix_free;
    logic       row_end;
    logic       last;

    function automatic ter_x_t min3(input ter_x_t a, input ter_x_t b, input ter_x_t c);
        ter_x_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic ter_x_t max3(input ter_x_t a, input ter_x_t b, input ter_x_t c);
        ter_x_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Gather vertex fields of the pending request
    always_comb begin
        in_x[0] = item.ax;
        in_x[1] = item.bx;
        in_x[2] = item.cx;
        in_y[0] = item.ay;
        in_y[1] = item.by_coord;
        in_y[2] = item.cy;
    end

    // Take a load at once; take a step when idle or when the pixel slot frees
    assign pix_free = !pix_valid_reg || dn_ready;
    assign is_load  = (item.op == OP_LOAD);
    assign emit     = in_valid && !is_load && active_reg && pix_free;
    assign in_take  = in_valid && (is_load || !active_reg || pix_free);

    assign row_end = (scan_x_reg == right_reg);
    assign last    = row_end && (scan_y_reg == bottom_reg);

    // Advance the scan position or restart it on a load
    always_comb begin
        active_next = active_reg;
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        if (in_valid && is_load) begin
            left_next   = min3(in_x[0], in_x[1], in_x[2]);
            right_next  = max3(in_x[0], in_x[1], in_x[2]);
            bottom_next = Y_W'(max3({1'b0, in_y[0]}, {1'b0, in_y[1]}, {1'b0, in_y[2]}));
            scan_x_next = left_next;
            scan_y_next = Y_W'(min3({1'b0, in_y[0]}, {1'b0, in_y[1]}, {1'b0, in_y[2]}));
            active_next = 1'b1;
        end else if (emit) begin
            if (last) begin
                active_next = 1'b0;
            end else if (row_end) begin
                scan_x_next = left_reg;
                scan_y_next = scan_y_reg + 1'b1;
            end else begin
                scan_x_next = scan_x_reg + 1'b1;
            end
        end
    end

    // Build the position record
    always_comb begin
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg && !dn_ready;
        if (emit) begin
            pix_valid_next = 1'b1;
            pix_next.x     = scan_x_reg;
            pix_next.y     = scan_y_reg;
            pix_next.color = color_reg;
            pix_next.last  = last;
            for (int i = 0; i < 3; i++) begin
                pix_next.dxp[i] = {1'b0, scan_x_reg} - {1'b0, vx_reg[i]};
                pix_next.dyp[i] = {1'b0, scan_y_reg} - {1'b0, vy_reg[i]};
                pix_next.ex[i]  = ex_reg[i];
                pix_next.ey[i]  = ey_reg[i];
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Triangle store, scan position and record payload
    always_ff @(posedge aclk) begin
        scan_x_reg <= scan_x_next;
        scan_y_reg <= scan_y_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        pix_reg    <= pix_next;
        if (in_valid && is_load) begin
            color_reg <= item.paint;
            for (int i = 0; i < 3; i++) begin
                vx_reg[i] <= in_x[i];
                vy_reg[i] <= in_y[i];
                ex_reg[i] <= {1'b0, in_x[(i + 1) % 3]} - {1'b0, in_x[i]};
                ey_reg[i] <= {1'b0, in_y[(i + 1) % 3]} - {1'b0, in_y[i]};
            end
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

`default_nettype wire

[rtl/ter_edge.sv]
// Edge-function products, coverage test and result register.
`default_nettype none

module ter_edge import ter_pkg::*; #(
    parameter int SCREEN_W = SCREEN_W_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pix_valid,
    input  wire ter_pix_t            pix,
    output logic                     pix_ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int P_W = DX_W + DY_W;
    localparam logic [ADDR_W-1:0] PITCH = ADDR_W'(SCREEN_W);

    typedef logic signed [P_W-1:0] ter_prod_t;

    logic                prod_valid_reg, prod_valid_next;
    ter_x_t              prod_x_reg;
    ter_y_t              prod_y_reg;
    ter_color_t          prod_color_reg;
    logic                prod_last_reg;
    logic [ADDR_W-1:0]   prod_addr_reg;
    ter_prod_t           pa_reg [3];
    ter_prod_t           pb_reg [3];

    logic                out_valid_reg, out_valid_next;
    ter_x_t              out_x_reg;
    ter_y_t              out_y_reg;
    ter_color_t          out_color_reg;
    logic                out_last_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_cov_reg;

    logic                out_free;
    logic                prod_load;
    logic                out_load;
    logic [ADDR_W-1:0]   addr_sum;
    logic signed [P_W:0] t [3];
    logic                all_nonneg;
    logic                all_nonpos;

    // Handshake between the stages
    assign out_free        = !out_valid_reg || m_tready;
    assign pix_ready       = !prod_valid_reg || out_free;
    assign prod_load       = pix_valid && pix_ready;
    assign out_load        = prod_valid_reg && out_free;
    assign prod_valid_next = (prod_valid_reg && !out_free) || prod_load;
    assign out_valid_next  = (out_valid_reg && !m_tready) || out_load;

    // Frame-buffer offset, wrapping at the address width
    assign addr_sum = {{(ADDR_W - X_W){1'b0}}, pix.x} +
                      ({{(ADDR_W - Y_W){1'b0}}, pix.y} * PITCH);

    // Product stage
    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_x_reg     <= pix.x;
            prod_y_reg     <= pix.y;
            prod_color_reg <= pix.color;
            prod_last_reg  <= pix.last;
            prod_addr_reg  <= addr_sum;
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= $signed(pix.dxp[i]) * $signed(pix.ey[i]);
                pb_reg[i] <= $signed(pix.dyp[i]) * $signed(pix.ex[i]);
            end
        end
    end

    // Edge values and sign test
    always_comb begin
        all_nonneg = 1'b1;
        all_nonpos = 1'b1;
        for (int i = 0; i < 3; i++) begin
            t[i] = {pa_reg[i][P_W-1], pa_reg[i]} - {pb_reg[i][P_W-1], pb_reg[i]};
            if (t[i][P_W]) begin
                all_nonneg = 1'b0;
            end
            if (!t[i][P_W] && (t[i] != '0)) begin
                all_nonpos = 1'b0;
            end
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg     <= prod_x_reg;
            out_y_reg     <= prod_y_reg;
            out_color_reg <= prod_color_reg;
            out_last_reg  <= prod_last_reg;
            out_addr_reg  <= prod_addr_reg;
            out_cov_reg   <= all_nonneg || all_nonpos;
        end
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - X_W - Y_W - ADDR_W - COLOR_W){1'b0}},
                       out_color_reg, out_addr_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_cov_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[verif/tb_triangle_edge_rasterizer.sv]
// Self-checking testbench for the triangle edge rasterizer stream block.
`default_nettype none

module tb_triangle_edge_rasterizer;
    import ter_pkg::*;

    localparam int REQUEST_GOAL = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    // One predicted pixel result
    typedef struct {
        ter_x_t     x;
        ter_y_t     y;
        logic [15:0] addr;
        logic       covered;
        ter_color_t color;
        logic       last;
    } pixel_exp_t;

    // Predicts the rasterizer scan and checks each emitted pixel in order
    class raster_scoreboard;
        ter_x_t     vx[3];
        ter_y_t     vy[3];
        ter_color_t color;
        ter_x_t     scan_x, left, right;
        ter_y_t     scan_y, bottom;
        bit         active;
        pixel_exp_t pixel_q[$];
        int         failures;

        function new();
            for (int i = 0; i < 3; i++) begin
                vx[i] = '0;
                vy[i] = '0;
            end
            color    = '0;
            scan_x   = '0;
            scan_y   = '0;
            left     = '0;
            right    = '0;
            bottom   = '0;
            active   = 1'b0;
            failures = 0;
        endfunction

        function int min3(int a, int b, int c);
            int m;
            m = (a < b) ? a : b;
            return (m < c) ? m : c;
        endfunction

        function int max3(int a, int b, int c);
            int m;
            m = (a > b) ? a : b;
            return (m > c) ? m : c;
        endfunction

        // Edge function of the scan point against the edge from vertex i to j
        function int edge_term(int i, int j);
            int xi, yi, xj, yj, px, py;
            xi = int'(vx[i]);
            yi = int'(vy[i]);
            xj = int'(vx[j]);
            yj = int'(vy[j]);
            px = int'(scan_x);
            py = int'(scan_y);
            return (px - xi) * (yj - yi) - (py - yi) * (xj - xi);
        endfunction

        // Note an accepted request; return 1 when it loads or yields a pixel
        function bit note_request(ter_item_t it);
            int         t1, t2, t3;
            pixel_exp_t p;
            if (it.op == OP_LOAD) begin
                vx[0] = it.ax;
                vy[0] = it.ay;
                vx[1] = it.bx;
                vy[1] = it.by_coord;
                vx[2] = it.cx;
                vy[2] = it.cy;
                color = it.paint;
                left   = ter_x_t'(min3(vx[0], vx[1], vx[2]));
                right  = ter_x_t'(max3(vx[0], vx[1], vx[2]));
                bottom = ter_y_t'(max3(vy[0], vy[1], vy[2]));
                scan_x = left;
                scan_y = ter_y_t'(min3(vy[0], vy[1], vy[2]));
                active = 1'b1;
                return 1'b1;
            end
            // Drop steps while idle
            if (!active) return 1'b0;
            t1 = edge_term(0, 1);
            t2 = edge_term(1, 2);
            t3 = edge_term(2, 0);
            p.x       = scan_x;
            p.y       = scan_y;
            p.addr    = 16'(int'(scan_x) + int'(scan_y) * SCREEN_W_DEF);
            p.covered = (t1 >= 0 && t2 >= 0 && t3 >= 0) || (t1 <= 0 && t2 <= 0 && t3 <= 0);
            p.color   = color;
            p.last    = (scan_x == right) && (scan_y == bottom);
            pixel_q.push_back(p);
            // Advance the scan in row-major order
            if (p.last) begin
                active = 1'b0;
            end else if (scan_x == right) begin
                scan_x = left;
                scan_y = scan_y + 1'b1;
            end else begin
                scan_x = scan_x + 1'b1;
            end
            return 1'b1;
        endfunction

        // Compare one accepted pixel with the oldest prediction
        function void check_result(logic [M_DATA_W-1:0] data, logic cov, logic last);
            pixel_exp_t p;
            bit         bad;
            if (pixel_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel x=%0d y=%0d addr=%0d cov=%0b color=%0d last=%0b",
                             data[8:0], data[16:9], data[32:17], cov, data[40:33], last);
                return;
            end
            p   = pixel_q.pop_front();
            bad = 1'b0;
            if (data[8:0]   !== p.x)       bad = 1'b1;
            if (data[16:9]  !== p.y)       bad = 1'b1;
            if (data[32:17] !== p.addr)    bad = 1'b1;
            if (data[40:33] !== p.color)   bad = 1'b1;
            if (data[47:41] !== '0)        bad = 1'b1;
            if (cov         !== p.covered) bad = 1'b1;
            if (last        !== p.last)    bad = 1'b1;
            if (bad) begin
                failures++;
                if (failures <= 10)
                    $display({"pixel mismatch: exp x=%0d y=%0d addr=%0d cov=%0b color=%0d",
                              " last=%0b | got x=%0d y=%0d addr=%0d cov=%0b color=%0d last=%0b"},
                             p.x, p.y, p.addr, p.covered, p.color, p.last,
                             data[8:0], data[16:9], data[32:17], cov, data[40:33], last);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    raster_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int useful_count;
    bit stall_req;

    triangle_edge_rasterizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop on a hang
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Pack request fields into the stream word, ax in the lowest bits
    function automatic logic [S_DATA_W-1:0] pack_request(ter_item_t it);
        logic [S_DATA_W-1:0] d;
        d        = '0;
        d[8:0]   = it.ax;
        d[16:9]  = it.ay;
        d[25:17] = it.bx;
        d[33:26] = it.by_coord;
        d[42:34] = it.cx;
        d[50:43] = it.cy;
        d[58:51] = it.paint;
        return d;
    endfunction

    // Fill every field at random across its whole width
    function automatic ter_item_t random_fields();
        ter_item_t it;
        it.op       = 1'($urandom_range(1));
        it.ax       = ter_x_t'($urandom_range(511));
        it.ay       = ter_y_t'($urandom_range(255));
        it.bx       = ter_x_t'($urandom_range(511));
        it.by_coord = ter_y_t'($urandom_range(255));
        it.cx       = ter_x_t'($urandom_range(511));
        it.cy       = ter_y_t'($urandom_range(255));
        it.paint    = ter_color_t'($urandom_range(255));
        return it;
    endfunction

    // Offer one request, idling at random first, and note it once accepted
    task automatic send_request(ter_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(it);
        s_tuser  <= it.op;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_request(it)) useful_count++;
    endtask

    task automatic send_load(int ax, int ay, int bx, int by_c, int cx, int cy, int paint);
        ter_item_t it;
        it.op       = OP_LOAD;
        it.ax       = ter_x_t'(ax);
        it.ay       = ter_y_t'(ay);
        it.bx       = ter_x_t'(bx);
        it.by_coord = ter_y_t'(by_c);
        it.cx       = ter_x_t'(cx);
        it.cy       = ter_y_t'(cy);
        it.paint    = ter_color_t'(paint);
        send_request(it);
    endtask

    // Step requests carry junk in the vertex fields, which the block ignores
    task automatic send_steps(int count);
        ter_item_t it;
        for (int i = 0; i < count; i++) begin
            it    = random_fields();
            it.op = OP_STEP;
            send_request(it);
        end
    endtask

    // Load a triangle with vertices clustered within spread; return its box area
    task automatic load_cluster(int spread, output int area);
        int bx0, by0, xs[3], ys[3], xmin, xmax, ymin, ymax;
        bx0 = $urandom_range(511 - spread);
        by0 = $urandom_range(255 - spread);
        for (int i = 0; i < 3; i++) begin
            xs[i] = bx0 + $urandom_range(spread);
            ys[i] = by0 + $urandom_range(spread);
        end
        xmin = xs[0]; xmax = xs[0]; ymin = ys[0]; ymax = ys[0];
        for (int i = 1; i < 3; i++) begin
            if (xs[i] < xmin) xmin = xs[i];
            if (xs[i] > xmax) xmax = xs[i];
            if (ys[i] < ymin) ymin = ys[i];
            if (ys[i] > ymax) ymax = ys[i];
        end
        area = (xmax - xmin + 1) * (ymax - ymin + 1);
        send_load(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom_range(255));
    endtask

    // Receiver: random backpressure plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every accepted pixel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Stimulus
    initial begin
        int roll, spread, area, n;
        bit pressure_done;
        sb            = new();
        tx_idle_pct   = 26;
        rx_idle_pct   = 26;
        useful_count  = 0;
        stall_req     = 1'b0;
        pressure_done = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_LOAD;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Steps with no triangle loaded
        send_steps(2);
        // Single-point box at the origin, then a step after the box is done
        send_load(0, 0, 0, 0, 0, 0, 0);
        send_steps(2);
        // Single point at the largest coordinates, off screen, address wraps
        send_load(511, 255, 511, 255, 511, 255, 255);
        send_steps(1);
        // Degenerate horizontal line covers its row
        send_load(10, 5, 12, 5, 11, 5, 8'hA5);
        send_steps(3);
        // Start one winding, then reload mid-scan with the opposite winding
        send_load(0, 0, 2, 0, 0, 2, 8'h5A);
        send_steps(3);
        send_load(300, 190, 300, 192, 302, 190, 8'hC3);
        send_steps(9);

        // Random part: mostly complete scans, some cut short, some noise
        while (useful_count < REQUEST_GOAL) begin
            if (useful_count >= 700 && useful_count < 950) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 26;
                rx_idle_pct = 26;
            end
            if (!pressure_done && useful_count >= 400) begin
                // Hold the output off while a large box keeps the input busy
                pressure_done = 1'b1;
                send_load(100, 50, 130, 50, 100, 70, $urandom_range(255));
                stall_req = 1'b1;
                send_steps(31 * 21);
                continue;
            end
            roll   = $urandom_range(99);
            spread = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(5);
            if (roll < 80) begin
                load_cluster(spread, area);
                n = area + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
                send_steps(n);
            end else if (roll < 92) begin
                load_cluster(spread, area);
                send_steps($urandom_range(area));
            end else begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) send_request(random_fields());
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding pixels, then allow the pipeline to settle
        while (sb.pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pixel_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
